/* rtl/lgd_pkg.sv */
// Shared types, codes and helpers of the linear regression trainer.
package lgd_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 128;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned DIV_W           = 64;
  localparam int unsigned GRAD_W          = 48;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd2;

  localparam logic [15:0] LEARN_RATE_RST     = 16'd655;
  localparam logic [31:0] STOP_THRESHOLD_RST = 32'd4295;
  localparam logic [7:0]  MAX_ITERATIONS_RST = 8'd100;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_TRAIN   = 2'd2;
  localparam logic [1:0] CMD_PREDICT = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] init_bias;
    logic signed [31:0] init_slope;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] bias_out;
    logic signed [31:0] slope_out;
    logic [63:0]        cost_out;
    logic signed [31:0] prediction;
    logic [7:0]         passes_used;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_CLEAR, OP_LOAD, OP_FULL, OP_EMPTY, OP_TINIT,
    OP_RD, OP_MSX, OP_RES, OP_MDD, OP_MDX, OP_ACC,
    OP_DIVC, OP_DIV0, OP_DIV1, OP_FIRST, OP_EVAL, OP_UMUL, OP_UPD,
    OP_PMUL, OP_PRED, OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    SEL_COST, SEL_G0, SEL_G1
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEC, ST_RD, ST_MSX, ST_RES, ST_MDD, ST_MDX, ST_ACC,
    ST_DIVC, ST_WDC, ST_DIV0, ST_WD0, ST_DIV1, ST_WD1, ST_EVAL,
    ST_UMUL, ST_UPD, ST_PMUL, ST_PRED, ST_DONE
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       cnt_zero;
    logic       cnt_full;
    logic       last;
    logic       div_done;
    logic       first;
    logic       maxit_zero;
    logic       stop;
    logic       passes_last;
  } dp_stat_t;

  // Clamp to a signed w-bit range, returned in the 32-bit field.
  function automatic logic [31:0] sat_val(input logic signed [63:0] v,
                                          input int unsigned w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[31:0];
    else if (v < lo) return lo[31:0];
    else return v[31:0];
  endfunction

endpackage

/* rtl/linreg_gradient_descent_trainer.sv */
// Linear regression trainer: loads (x, y) samples and fits y = bias + slope*x by
// batch gradient descent in Q16.16, with the cost in Q32.32. Each command gives one
// result item. Train walks the store once for the starting cost and once per pass, reading
// each sample, then forming slope*x, its residual, the square and the product with x on the
// shared 32x32 multiplier and accumulating them, then runs three divisions (cost and both
// mean gradients) on one serial divider. A new item is taken while the previous result
// still waits at the output.
module linreg_gradient_descent_trainer #(
  parameter int unsigned MAX_SAMPLES = lgd_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned VALUE_WIDTH = lgd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lgd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lgd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lgd_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lgd_pkg::out_item_t             out_data_o
);

  lgd_pkg::dp_cmd_t  dp_cmd;
  lgd_pkg::dp_stat_t dp_stat;

  lgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  lgd_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .out_data_o(out_data_o)
  );

endmodule

/* rtl/lgd_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module lgd_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CNW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNW'(DW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/lgd_datapath.sv */
// Datapath: sample store, shared multiplier, sums, divider and parameter registers.
module lgd_datapath #(
  parameter int unsigned MAX_SAMPLES = lgd_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned VALUE_WIDTH = lgd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lgd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lgd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  lgd_pkg::in_item_t                   in_data_i,
  input  lgd_pkg::dp_cmd_t                    cmd_i,
  output lgd_pkg::dp_stat_t                   stat_o,
  output lgd_pkg::out_item_t                  out_data_o
);

  localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW    = $clog2(MAX_SAMPLES);
  localparam int unsigned SAT_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned S0W   = CW + 33;
  localparam int unsigned S1W   = CW + 48;
  localparam int unsigned GW    = lgd_pkg::GRAD_W;
  localparam int unsigned DW    = lgd_pkg::DIV_W;

  lgd_pkg::dp_op_e op;
  assign op = cmd_i.op;

  logic [15:0]             lr_q;
  logic [31:0]             thr_q;
  logic [7:0]              maxit_q;
  lgd_pkg::in_item_t       item_q;
  logic [CW-1:0]           count_q;
  logic signed [31:0]      bias_q, slope_q;
  logic [63:0]             prev_q;
  logic [1:0]              status_q;
  logic signed [31:0]      pred_q;
  logic [7:0]              passes_q;
  logic                    first_q;
  logic [AW-1:0]           idx_q;
  logic signed [31:0]      mx_q, my_q;
  logic signed [63:0]      prod_q;
  logic signed [31:0]      d_q;
  logic [63:0]             acc_q;
  logic signed [S0W-1:0]   s0_q;
  logic signed [S1W-1:0]   s1_q;
  logic [63:0]             cost_q;
  logic signed [GW-1:0]    g0_q, g1_q;
  logic signed [63:0]      step0_q, step1_q;
  lgd_pkg::div_sel_e       sel_q;
  logic                    neg_q;
  lgd_pkg::out_item_t      out_q;

  logic [63:0] mem [MAX_SAMPLES];

  function automatic logic [31:0] sat_init(input logic signed [31:0] v);
    return lgd_pkg::sat_val(64'(v), SAT_W);
  endfunction

  // Shared 32x32 multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    case (op)
      lgd_pkg::OP_MSX:  begin mul_a = slope_q; mul_b = mx_q; end
      lgd_pkg::OP_MDD:  begin mul_a = d_q;     mul_b = d_q;  end
      lgd_pkg::OP_MDX:  begin mul_a = d_q;     mul_b = mx_q; end
      lgd_pkg::OP_PMUL: begin mul_a = slope_q; mul_b = item_q.x_value; end
      default:          begin mul_a = slope_q; mul_b = mx_q; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [49:0] line_v, res_v;
  assign line_v = 50'(bias_q) + 50'(prod_q >>> 16);
  assign res_v  = line_v - 50'(my_q);

  logic [64:0] acc_sum;
  assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};

  logic signed [16:0] lr_s;
  assign lr_s = $signed({1'b0, lr_q});

  // Divider operands
  logic          div_start;
  logic [DW-1:0] div_dvd;
  logic [CW:0]   div_dvs;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic          div_neg;
  always_comb begin
    div_start = 1'b0;
    div_dvd   = acc_q;
    div_dvs   = {count_q, 1'b0};
    div_neg   = 1'b0;
    case (op)
      lgd_pkg::OP_DIVC: div_start = 1'b1;
      lgd_pkg::OP_DIV0: begin
        div_start = 1'b1;
        div_dvs   = {1'b0, count_q};
        div_neg   = s0_q[S0W-1];
        div_dvd   = s0_q[S0W-1] ? 64'(-s0_q) : 64'(s0_q);
      end
      lgd_pkg::OP_DIV1: begin
        div_start = 1'b1;
        div_dvs   = {1'b0, count_q};
        div_neg   = s1_q[S1W-1];
        div_dvd   = s1_q[S1W-1] ? 64'(-s1_q) : 64'(s1_q);
      end
      default: ;
    endcase
  end

  lgd_div #(.DW(DW), .VW(CW + 1)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  logic signed [GW-1:0] q_s;
  assign q_s = neg_q ? -$signed(GW'(div_quot)) : $signed(GW'(div_quot));

  // Configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q     <= lgd_pkg::LEARN_RATE_RST;
      thr_q    <= lgd_pkg::STOP_THRESHOLD_RST;
      maxit_q  <= lgd_pkg::MAX_ITERATIONS_RST;
      count_q  <= '0;
      bias_q   <= '0;
      slope_q  <= '0;
      prev_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lgd_pkg::REG_LEARN_RATE:     lr_q    <= cfg_data_i[15:0];
          lgd_pkg::REG_STOP_THRESHOLD: thr_q   <= cfg_data_i[31:0];
          lgd_pkg::REG_MAX_ITERATIONS: maxit_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (op)
        lgd_pkg::OP_CLEAR: count_q <= '0;
        lgd_pkg::OP_LOAD:  count_q <= count_q + CW'(1);
        lgd_pkg::OP_TINIT: begin
          bias_q  <= sat_init(item_q.init_bias);
          slope_q <= sat_init(item_q.init_slope);
        end
        lgd_pkg::OP_FIRST, lgd_pkg::OP_EVAL: prev_q <= cost_q;
        lgd_pkg::OP_UPD: begin
          bias_q  <= lgd_pkg::sat_val(64'(bias_q) - (step0_q >>> 16), SAT_W);
          slope_q <= lgd_pkg::sat_val(64'(slope_q) - (step1_q >>> 16), SAT_W);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (sel_q)
        lgd_pkg::SEL_COST: cost_q <= div_quot;
        lgd_pkg::SEL_G0:   g0_q   <= q_s;
        lgd_pkg::SEL_G1:   g1_q   <= q_s;
        default: ;
      endcase
    end
    if (div_start) neg_q <= div_neg;
    case (op)
      lgd_pkg::OP_CAPTURE: begin
        item_q   <= in_data_i;
        status_q <= lgd_pkg::STAT_OK;
        pred_q   <= '0;
        passes_q <= '0;
      end
      lgd_pkg::OP_FULL:  status_q <= lgd_pkg::STAT_FULL;
      lgd_pkg::OP_EMPTY: status_q <= lgd_pkg::STAT_EMPTY;
      lgd_pkg::OP_TINIT: begin
        first_q <= 1'b1;
        idx_q   <= '0;
        acc_q   <= '0;
        s0_q    <= '0;
        s1_q    <= '0;
      end
      lgd_pkg::OP_MSX, lgd_pkg::OP_MDD, lgd_pkg::OP_PMUL: prod_q <= mul_p;
      lgd_pkg::OP_RES: d_q <= lgd_pkg::sat_val(64'(res_v), 32);
      lgd_pkg::OP_MDX: begin
        acc_q  <= acc_sum[64] ? '1 : acc_sum[63:0];
        prod_q <= mul_p;
      end
      lgd_pkg::OP_ACC: begin
        s0_q  <= s0_q + S0W'(d_q);
        s1_q  <= s1_q + S1W'(prod_q >>> 16);
        idx_q <= idx_q + AW'(1);
      end
      lgd_pkg::OP_DIVC: sel_q <= lgd_pkg::SEL_COST;
      lgd_pkg::OP_DIV0: sel_q <= lgd_pkg::SEL_G0;
      lgd_pkg::OP_DIV1: sel_q <= lgd_pkg::SEL_G1;
      lgd_pkg::OP_FIRST: first_q <= 1'b0;
      lgd_pkg::OP_EVAL:  passes_q <= passes_q + 8'd1;
      lgd_pkg::OP_UMUL: begin
        step0_q <= lr_s * g0_q;
        step1_q <= lr_s * g1_q;
      end
      lgd_pkg::OP_UPD: begin
        idx_q <= '0;
        acc_q <= '0;
        s0_q  <= '0;
        s1_q  <= '0;
      end
      lgd_pkg::OP_PRED: pred_q <= lgd_pkg::sat_val(64'(bias_q) + (prod_q >>> 16), SAT_W);
      lgd_pkg::OP_OUT: begin
        out_q.status      <= status_q;
        out_q.bias_out    <= bias_q;
        out_q.slope_out   <= slope_q;
        out_q.cost_out    <= prev_q;
        out_q.prediction  <= pred_q;
        out_q.passes_used <= passes_q;
      end
      default: ;
    endcase
  end

  // Sample store
  always_ff @(posedge clk_i) begin
    if (op == lgd_pkg::OP_LOAD) begin
      mem[count_q[AW-1:0]] <= {item_q.x_value, item_q.y_value};
    end
    if (op == lgd_pkg::OP_RD) begin
      {mx_q, my_q} <= mem[idx_q];
    end
  end

  assign stat_o.cmd         = item_q.cmd;
  assign stat_o.cnt_zero    = (count_q == '0);
  assign stat_o.cnt_full    = (count_q >= CW'(MAX_SAMPLES));
  assign stat_o.last        = (CW'(idx_q) == count_q - CW'(1));
  assign stat_o.div_done    = div_done;
  assign stat_o.first       = first_q;
  assign stat_o.maxit_zero  = (maxit_q == '0);
  assign stat_o.stop        = (cost_q > prev_q) || ((prev_q - cost_q) < 64'(thr_q));
  assign stat_o.passes_last = (passes_q + 8'd1 == maxit_q);

  assign out_data_o = out_q;

endmodule

/* rtl/lgd_ctrl.sv */
// Controller: command sequencing, sample walk, training loop and handshakes.
module lgd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lgd_pkg::dp_stat_t stat_i,
  output lgd_pkg::dp_cmd_t  cmd_o
);

  lgd_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lgd_pkg::ST_IDLE: if (in_valid_i) state_d = lgd_pkg::ST_DEC;
      lgd_pkg::ST_DEC: begin
        case (stat_i.cmd)
          lgd_pkg::CMD_TRAIN:
            state_d = stat_i.cnt_zero ? lgd_pkg::ST_DONE : lgd_pkg::ST_RD;
          lgd_pkg::CMD_PREDICT: state_d = lgd_pkg::ST_PMUL;
          default:              state_d = lgd_pkg::ST_DONE;
        endcase
      end
      lgd_pkg::ST_RD:  state_d = lgd_pkg::ST_MSX;
      lgd_pkg::ST_MSX: state_d = lgd_pkg::ST_RES;
      lgd_pkg::ST_RES: state_d = lgd_pkg::ST_MDD;
      lgd_pkg::ST_MDD: state_d = lgd_pkg::ST_MDX;
      lgd_pkg::ST_MDX: state_d = lgd_pkg::ST_ACC;
      lgd_pkg::ST_ACC: state_d = stat_i.last ? lgd_pkg::ST_DIVC : lgd_pkg::ST_RD;
      lgd_pkg::ST_DIVC: state_d = lgd_pkg::ST_WDC;
      lgd_pkg::ST_WDC:  if (stat_i.div_done) state_d = lgd_pkg::ST_DIV0;
      lgd_pkg::ST_DIV0: state_d = lgd_pkg::ST_WD0;
      lgd_pkg::ST_WD0:  if (stat_i.div_done) state_d = lgd_pkg::ST_DIV1;
      lgd_pkg::ST_DIV1: state_d = lgd_pkg::ST_WD1;
      lgd_pkg::ST_WD1:  if (stat_i.div_done) state_d = lgd_pkg::ST_EVAL;
      lgd_pkg::ST_EVAL: begin
        if (stat_i.first) begin
          state_d = stat_i.maxit_zero ? lgd_pkg::ST_DONE : lgd_pkg::ST_UMUL;
        end else begin
          state_d = (stat_i.stop || stat_i.passes_last) ? lgd_pkg::ST_DONE
                                                         : lgd_pkg::ST_UMUL;
        end
      end
      lgd_pkg::ST_UMUL: state_d = lgd_pkg::ST_UPD;
      lgd_pkg::ST_UPD:  state_d = lgd_pkg::ST_RD;
      lgd_pkg::ST_PMUL: state_d = lgd_pkg::ST_PRED;
      lgd_pkg::ST_PRED: state_d = lgd_pkg::ST_DONE;
      lgd_pkg::ST_DONE: if (out_free) state_d = lgd_pkg::ST_IDLE;
      default: state_d = lgd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = lgd_pkg::OP_NONE;
    case (state_q)
      lgd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = lgd_pkg::OP_CAPTURE;
      end
      lgd_pkg::ST_DEC: begin
        case (stat_i.cmd)
          lgd_pkg::CMD_CLEAR: cmd_o.op = lgd_pkg::OP_CLEAR;
          lgd_pkg::CMD_LOAD:
            cmd_o.op = stat_i.cnt_full ? lgd_pkg::OP_FULL : lgd_pkg::OP_LOAD;
          lgd_pkg::CMD_TRAIN:
            cmd_o.op = stat_i.cnt_zero ? lgd_pkg::OP_EMPTY : lgd_pkg::OP_TINIT;
          default: cmd_o.op = lgd_pkg::OP_NONE;
        endcase
      end
      lgd_pkg::ST_RD:   cmd_o.op = lgd_pkg::OP_RD;
      lgd_pkg::ST_MSX:  cmd_o.op = lgd_pkg::OP_MSX;
      lgd_pkg::ST_RES:  cmd_o.op = lgd_pkg::OP_RES;
      lgd_pkg::ST_MDD:  cmd_o.op = lgd_pkg::OP_MDD;
      lgd_pkg::ST_MDX:  cmd_o.op = lgd_pkg::OP_MDX;
      lgd_pkg::ST_ACC:  cmd_o.op = lgd_pkg::OP_ACC;
      lgd_pkg::ST_DIVC: cmd_o.op = lgd_pkg::OP_DIVC;
      lgd_pkg::ST_DIV0: cmd_o.op = lgd_pkg::OP_DIV0;
      lgd_pkg::ST_DIV1: cmd_o.op = lgd_pkg::OP_DIV1;
      lgd_pkg::ST_EVAL:
        cmd_o.op = stat_i.first ? lgd_pkg::OP_FIRST : lgd_pkg::OP_EVAL;
      lgd_pkg::ST_UMUL: cmd_o.op = lgd_pkg::OP_UMUL;
      lgd_pkg::ST_UPD:  cmd_o.op = lgd_pkg::OP_UPD;
      lgd_pkg::ST_PMUL: cmd_o.op = lgd_pkg::OP_PMUL;
      lgd_pkg::ST_PRED: cmd_o.op = lgd_pkg::OP_PRED;
      lgd_pkg::ST_DONE: if (out_free) cmd_o.op = lgd_pkg::OP_OUT;
      default: cmd_o.op = lgd_pkg::OP_NONE;
    endcase
  end

  assign out_valid_d = (cmd_o.op == lgd_pkg::OP_OUT) ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/lgd_checker.sv */
// Port-level checks of the trainer, bound to the top level.
module lgd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lgd_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != lgd_pkg::STAT_OK
      |-> out_data_o.passes_used == 8'd0 && out_data_o.prediction == 32'sd0)
    else $error("error item carries passes or prediction");

  a_train_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.passes_used != 8'd0
      |-> out_data_o.status == lgd_pkg::STAT_OK && out_data_o.prediction == 32'sd0)
    else $error("train item with bad status or prediction");

endmodule

bind linreg_gradient_descent_trainer lgd_checker u_lgd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

/* dv/tb.sv */
// Testbench of the linear regression trainer: directed table, a store fill, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSAMP = 128;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lgd_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [lgd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lgd_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lgd_pkg::out_item_t out_data_o;

  linreg_gradient_descent_trainer u_top (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state
  longint sx [NSAMP];
  longint sy [NSAMP];
  int unsigned n_samp;
  longint fit_bias, fit_slope;
  longint unsigned fit_cost;
  longint unsigned lr_q16, stop_thr, iter_cap;

  lgd_pkg::out_item_t pending_results[$];
  int unsigned n_errors;
  bit calm;

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint resid_at(longint b, longint s, int i);
    return clamp32(b + fl16(s * sx[i]) - sy[i]);
  endfunction

  function automatic longint unsigned cost_at(longint b, longint s);
    logic [64:0] acc;
    longint d;
    acc = '0;
    for (int i = 0; i < n_samp; i++) begin
      d = resid_at(b, s, i);
      acc = acc + 65'(longint'(d * d));
      if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return acc[63:0] / (64'd2 * n_samp);
  endfunction

  function automatic void descend_once();
    longint s0, s1, g0, g1, d;
    s0 = 0;
    s1 = 0;
    for (int i = 0; i < n_samp; i++) begin
      d = resid_at(fit_bias, fit_slope, i);
      s0 += d;
      s1 += fl16(d * sx[i]);
    end
    g0 = s0 / longint'(n_samp);
    g1 = s1 / longint'(n_samp);
    fit_bias = clamp32(fit_bias - fl16(longint'(lr_q16) * g0));
    fit_slope = clamp32(fit_slope - fl16(longint'(lr_q16) * g1));
  endfunction

  function automatic lgd_pkg::out_item_t trainer_step(lgd_pkg::in_item_t it);
    lgd_pkg::out_item_t r;
    longint unsigned prev;
    int unsigned passes;
    r = '0;
    passes = 0;
    case (it.cmd)
      lgd_pkg::CMD_CLEAR: n_samp = 0;
      lgd_pkg::CMD_LOAD: begin
        if (n_samp >= NSAMP) r.status = lgd_pkg::STAT_FULL;
        else begin
          sx[n_samp] = longint'(it.x_value);
          sy[n_samp] = longint'(it.y_value);
          n_samp++;
        end
      end
      lgd_pkg::CMD_TRAIN: begin
        if (n_samp == 0) r.status = lgd_pkg::STAT_EMPTY;
        else begin
          fit_bias = longint'(it.init_bias);
          fit_slope = longint'(it.init_slope);
          fit_cost = cost_at(fit_bias, fit_slope);
          while (passes < iter_cap) begin
            prev = fit_cost;
            descend_once();
            fit_cost = cost_at(fit_bias, fit_slope);
            passes++;
            if (fit_cost > prev || prev - fit_cost < stop_thr) break;
          end
        end
      end
      default:
        r.prediction = 32'(clamp32(fit_bias + fl16(fit_slope * longint'(it.x_value))));
    endcase
    r.bias_out = fit_bias[31:0];
    r.slope_out = fit_slope[31:0];
    r.cost_out = fit_cost;
    r.passes_used = passes[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic int unsigned draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Sender: called at a falling edge, returns at a falling edge.
  task automatic send_item(lgd_pkg::in_item_t it, bit typed, lgd_pkg::out_item_t typed_res);
    int unsigned gap;
    lgd_pkg::out_item_t r;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    r = trainer_step(it);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [lgd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      lgd_pkg::REG_LEARN_RATE:     lr_q16 = val[15:0];
      lgd_pkg::REG_STOP_THRESHOLD: stop_thr = val;
      default:                     iter_cap = val[7:0];
    endcase
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] lr, logic [31:0] thr, logic [7:0] cap);
    drain();
    write_reg(lgd_pkg::REG_LEARN_RATE, {16'd0, lr});
    write_reg(lgd_pkg::REG_STOP_THRESHOLD, thr);
    write_reg(lgd_pkg::REG_MAX_ITERATIONS, {24'd0, cap});
  endtask

  // Samples mostly lie near a small line so training converges; some are raw noise.
  function automatic lgd_pkg::in_item_t random_item(logic [1:0] cmd);
    lgd_pkg::in_item_t it;
    int bb, ss, xx;
    it.cmd = cmd;
    bb = $urandom_range(0, 32 * 65536) - 16 * 65536;
    ss = $urandom_range(0, 8 * 65536) - 4 * 65536;
    xx = $urandom_range(0, 1 << 20) - (1 << 19);
    it.x_value = xx;
    it.y_value = bb + ((longint'(ss) * xx) >>> 16) + $urandom_range(0, 8191) - 4096;
    it.init_bias = $urandom_range(0, 8 * 65536) - 4 * 65536;
    it.init_slope = $urandom_range(0, 4 * 65536) - 2 * 65536;
    if ($urandom_range(0, 4) == 0) begin
      it.x_value = $urandom;
      it.y_value = $urandom;
    end
    if ($urandom_range(0, 5) == 0) begin
      it.init_bias = $urandom;
      it.init_slope = $urandom;
    end
    return it;
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned pick;
    logic [1:0] cmd;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) cmd = lgd_pkg::CMD_CLEAR;
      else if (pick < 60) cmd = lgd_pkg::CMD_LOAD;
      else if (pick < 75) cmd = lgd_pkg::CMD_TRAIN;
      else cmd = lgd_pkg::CMD_PREDICT;
      send_item(random_item(cmd), 1'b0, '0);
    end
  endtask

  typedef struct {
    logic [1:0] cmd;
    int x, y, b, s;
    bit typed;
    lgd_pkg::out_item_t res;
  } stim_row_t;

  localparam int MAXV = 32'sh7FFF_FFFF;
  localparam int MINV = 32'sh8000_0000;

  stim_row_t directed [] = '{
    '{lgd_pkg::CMD_PREDICT, MAXV, 0, 0, 0, 1'b1, '0},
    '{lgd_pkg::CMD_TRAIN, 0, 0, 65536, 65536, 1'b1,
      '{lgd_pkg::STAT_EMPTY, 32'sd0, 32'sd0, 64'd0, 32'sd0, 8'd0}},
    '{lgd_pkg::CMD_LOAD, MAXV, MINV, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_LOAD, MINV, MAXV, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_LOAD, 0, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_LOAD, 65536, 131072, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_TRAIN, 0, 0, MAXV, MINV, 1'b0, '0},
    '{lgd_pkg::CMD_PREDICT, MINV, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_PREDICT, MAXV, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_TRAIN, 0, 0, MINV, MAXV, 1'b0, '0},
    '{lgd_pkg::CMD_TRAIN, 0, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_PREDICT, 65536, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_TRAIN, 0, 0, 5, 5, 1'b0, '0},
    '{lgd_pkg::CMD_LOAD, 65536, 196608, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_LOAD, 131072, 327680, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_LOAD, -65536, -65536, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_TRAIN, 0, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_PREDICT, 196608, 0, 0, 0, 1'b0, '0},
    '{lgd_pkg::CMD_PREDICT, 0, 0, 0, 0, 1'b0, '0}
  };

  // Result checker
  initial begin
    lgd_pkg::out_item_t want;
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", out_data_o.cost_out, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
        if (out_data_o.bias_out !== want.bias_out)
          report_mismatch("bias_out", 64'(out_data_o.bias_out), 64'(want.bias_out));
        if (out_data_o.slope_out !== want.slope_out)
          report_mismatch("slope_out", 64'(out_data_o.slope_out), 64'(want.slope_out));
        if (out_data_o.cost_out !== want.cost_out)
          report_mismatch("cost_out", out_data_o.cost_out, want.cost_out);
        if (out_data_o.prediction !== want.prediction)
          report_mismatch("prediction", 64'(out_data_o.prediction), 64'(want.prediction));
        if (out_data_o.passes_used !== want.passes_used)
          report_mismatch("passes_used", 64'(out_data_o.passes_used),
                          64'(want.passes_used));
      end
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    lgd_pkg::in_item_t it;
    n_errors = 0;
    n_samp = 0;
    fit_bias = 0;
    fit_slope = 0;
    fit_cost = 0;
    lr_q16 = 655;
    stop_thr = 4295;
    iter_cap = 100;
    calm = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      it.cmd = directed[i].cmd;
      it.x_value = directed[i].x;
      it.y_value = directed[i].y;
      it.init_bias = directed[i].b;
      it.init_slope = directed[i].s;
      send_item(it, directed[i].typed, directed[i].res);
    end

    // fill the store, then one load too many
    set_regs(16'd655, 32'd4295, 8'd1);
    send_item(random_item(lgd_pkg::CMD_CLEAR), 1'b0, '0);
    repeat (NSAMP) send_item(random_item(lgd_pkg::CMD_LOAD), 1'b0, '0);
    it = random_item(lgd_pkg::CMD_LOAD);
    send_item(it, 1'b0, '0);
    send_item(random_item(lgd_pkg::CMD_TRAIN), 1'b0, '0);
    send_item(random_item(lgd_pkg::CMD_PREDICT), 1'b0, '0);
    send_item(random_item(lgd_pkg::CMD_CLEAR), 1'b0, '0);

    set_regs(16'hFFFF, 32'd0, 8'd255);
    random_phase(30);
    set_regs(16'd0, 32'hFFFF_FFFF, 8'd1);
    random_phase(60);
    set_regs(16'($urandom), 32'($urandom_range(0, 1 << 24)), 8'($urandom_range(1, 20)));
    random_phase(120);
    set_regs(16'd6554, 32'd1 << 20, 8'd20);
    random_phase(120);
    calm = 1'b1;
    set_regs(16'($urandom), 32'd0, 8'd8);
    random_phase(60);
    calm = 1'b0;
    random_phase(60);

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
